>>> rtl/hec_pkg.sv
// Shared types and constants for the heavy-edge coarse mapping block.
package hec_pkg;

  localparam int unsigned VTX_W   = 12;
  localparam int unsigned ID_W    = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned VTX_SPACE = 4096;

  localparam logic [CNT_W-1:0] VC_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_VISIT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_UNMAPPED = 2'd2;

  // One entry of the mapping memory.
  typedef struct packed {
    logic            mapped;
    logic [ID_W-1:0] id;
  } hec_map_t;

  // One result word handed from the sequencer to the output register.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  coarse_id;
    logic             created_new;
    logic [CNT_W-1:0] coarse_count;
  } hec_res_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK1 = 6'b000100,
    S_LOOK2 = 6'b001000,
    S_WRU   = 6'b010000,
    S_RESP  = 6'b100000
  } hec_state_t;

endpackage

>>> rtl/hec_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module hec_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hec_seq.sv
// Sequencer: clearing pass, per-item read-modify-write of the edge and mapping memories.
module hec_seq #(
  parameter int unsigned DEPTH       = 4096,
  parameter int unsigned AW          = 12,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hec_pkg::OP_W-1:0]     in_op,
  input  logic [hec_pkg::VTX_W-1:0]    in_vertex,
  input  logic [hec_pkg::VTX_W-1:0]    in_neighbor,
  input  logic [31:0]                  in_weight,
  input  logic [hec_pkg::CNT_W-1:0]    vertex_count,
  input  logic                         out_free,
  output logic                         res_valid,
  output hec_pkg::hec_res_t            res,
  output logic                         e_we,
  output logic [AW-1:0]                e_waddr,
  output logic [WEIGHT_BITS+AW-1:0]    e_wdata,
  output logic [AW-1:0]                e_raddr,
  input  logic [WEIGHT_BITS+AW-1:0]    e_rdata,
  output logic                         m_we,
  output logic [AW-1:0]                m_waddr,
  output hec_pkg::hec_map_t            m_wdata,
  output logic [AW-1:0]                m_raddr,
  input  hec_pkg::hec_map_t            m_rdata
);

  localparam logic [hec_pkg::CNT_W-1:0] DEPTH_C = hec_pkg::CNT_W'(DEPTH);

  hec_pkg::hec_state_t state_r, state_nxt;
  logic [AW-1:0]                clr_r;
  logic [hec_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [hec_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [AW-1:0]                u_r, u_nxt;
  logic [AW-1:0]                nb_r, nb_nxt;
  logic [AW-1:0]                v_r, v_nxt;
  logic [WEIGHT_BITS-1:0]       w_r, w_nxt;
  logic [hec_pkg::ID_W-1:0]     id_r, id_nxt;
  hec_pkg::hec_res_t            res_r, res_nxt;

  logic                         fin;
  hec_pkg::hec_res_t            fin_res;
  logic                         u_ok, nb_ok, v_ok;
  logic [WEIGHT_BITS-1:0]       bw;
  logic [AW-1:0]                bnb;
  logic [AW-1:0]                v_sel;

  assign bw    = e_rdata[AW +: WEIGHT_BITS];
  assign bnb   = e_rdata[AW-1:0];
  // An item with no winning edge is its own heaviest neighbour.
  assign v_sel = (bw == '0) ? u_r : bnb;

  assign u_ok  = (hec_pkg::CNT_W'(in_vertex) < vertex_count) &&
                 (hec_pkg::CNT_W'(in_vertex) < DEPTH_C);
  assign nb_ok = (hec_pkg::CNT_W'(in_neighbor) < vertex_count) &&
                 (hec_pkg::CNT_W'(in_neighbor) < DEPTH_C);
  assign v_ok  = (hec_pkg::CNT_W'(v_sel) < vertex_count) &&
                 (hec_pkg::CNT_W'(v_sel) < DEPTH_C);

  assign in_stall = (state_r != hec_pkg::S_IDLE);
  assign e_raddr  = in_vertex[AW-1:0];
  assign m_raddr  = (state_r == hec_pkg::S_LOOK1) ? v_sel : in_vertex[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    u_nxt     = u_r;
    nb_nxt    = nb_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    id_nxt    = id_r;
    res_nxt   = res_r;
    res_valid = 1'b0;
    res       = res_r;
    fin       = 1'b0;
    fin_res   = '0;
    e_we      = 1'b0;
    e_waddr   = u_r;
    e_wdata   = {w_r, nb_r};
    m_we      = 1'b0;
    m_waddr   = u_r;
    m_wdata   = '0;

    unique case (state_r)
      hec_pkg::S_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_r;
        e_wdata = '0;
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = hec_pkg::S_IDLE;
        end
      end
      hec_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          u_nxt  = in_vertex[AW-1:0];
          nb_nxt = in_neighbor[AW-1:0];
          w_nxt  = in_weight[WEIGHT_BITS-1:0];
          priority if (in_op == hec_pkg::OP_LOAD) begin
            if (!u_ok || !nb_ok) begin
              fin            = 1'b1;
              fin_res.status = hec_pkg::ST_RANGE;
            end else begin
              state_nxt = hec_pkg::S_LOOK1;
            end
          end else if (in_op == hec_pkg::OP_VISIT || in_op == hec_pkg::OP_READ) begin
            if (!u_ok) begin
              fin            = 1'b1;
              fin_res.status = hec_pkg::ST_RANGE;
            end else begin
              state_nxt = hec_pkg::S_LOOK1;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      hec_pkg::S_LOOK1: begin
        unique case (op_r)
          hec_pkg::OP_LOAD: begin
            e_we = (w_r > bw);
            fin  = 1'b1;
          end
          hec_pkg::OP_READ: begin
            fin = 1'b1;
            if (m_rdata.mapped) begin
              fin_res.coarse_id = m_rdata.id;
            end else begin
              fin_res.status = hec_pkg::ST_UNMAPPED;
            end
          end
          hec_pkg::OP_VISIT: begin
            v_nxt = v_sel;
            if (m_rdata.mapped) begin
              fin               = 1'b1;
              fin_res.coarse_id = m_rdata.id;
            end else if (!v_ok) begin
              fin            = 1'b1;
              fin_res.status = hec_pkg::ST_RANGE;
            end else begin
              state_nxt = hec_pkg::S_LOOK2;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      hec_pkg::S_LOOK2: begin
        if (m_rdata.mapped) begin
          m_we              = 1'b1;
          m_waddr           = u_r;
          m_wdata.mapped    = 1'b1;
          m_wdata.id        = m_rdata.id;
          fin               = 1'b1;
          fin_res.coarse_id = m_rdata.id;
        end else begin
          m_we           = 1'b1;
          m_waddr        = v_r;
          m_wdata.mapped = 1'b1;
          m_wdata.id     = cnt_r[hec_pkg::ID_W-1:0];
          id_nxt         = cnt_r[hec_pkg::ID_W-1:0];
          cnt_nxt        = cnt_r + 1'b1;
          if (v_r == u_r) begin
            fin                 = 1'b1;
            fin_res.coarse_id   = cnt_r[hec_pkg::ID_W-1:0];
            fin_res.created_new = 1'b1;
          end else begin
            state_nxt = hec_pkg::S_WRU;
          end
        end
      end
      hec_pkg::S_WRU: begin
        m_we                = 1'b1;
        m_waddr             = u_r;
        m_wdata.mapped      = 1'b1;
        m_wdata.id          = id_r;
        fin                 = 1'b1;
        fin_res.coarse_id   = id_r;
        fin_res.created_new = 1'b1;
      end
      hec_pkg::S_RESP: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = hec_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hec_pkg::S_IDLE;
      end
    endcase

    fin_res.coarse_count = cnt_nxt;
    if (fin) begin
      if (out_free) begin
        res_valid = 1'b1;
        res       = fin_res;
        state_nxt = hec_pkg::S_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = hec_pkg::S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hec_pkg::S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == hec_pkg::S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    u_r   <= u_nxt;
    nb_r  <= nb_nxt;
    v_r   <= v_nxt;
    w_r   <= w_nxt;
    id_r  <= id_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/heavy_edge_coarse_mapping.sv
// A rejected or unused-op word finishes in S_IDLE as it is accepted, a load or read in S_LOOK1,
// a visit in S_LOOK1, S_LOOK2 or S_WRU (S_WRU when a fresh id is written to both ends of the edge).
// A word is taken only in S_IDLE (rejected and unused-op words every cycle while the output is
// free); the single mapping-memory write port and the dependent reads set the longest path.
// Reset (synchronous, rst_n low) clears control state, then a clearing pass over
// min(MAX_VERTICES, 4096) entries zeroes both memories with in_stall high; cfg writes still land.
module heavy_edge_coarse_mapping #(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [hec_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hec_pkg::OP_W-1:0]     in_op,
  input  logic [hec_pkg::VTX_W-1:0]    in_vertex,
  input  logic [hec_pkg::VTX_W-1:0]    in_neighbor,
  input  logic [31:0]                  in_weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hec_pkg::ST_W-1:0]     out_status,
  output logic [hec_pkg::ID_W-1:0]     out_coarse_id,
  output logic                         out_created_new,
  output logic [hec_pkg::CNT_W-1:0]    out_coarse_count
);

  // Vertex numbers are 12 bits wide, so no more than 4096 entries can ever be addressed.
  localparam int unsigned DEPTH = (MAX_VERTICES < hec_pkg::VTX_SPACE) ?
                                  MAX_VERTICES : hec_pkg::VTX_SPACE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = WEIGHT_BITS + AW;
  localparam int unsigned MW    = $bits(hec_pkg::hec_map_t);

  // The vertex_count register; the limit in force is its minimum with the memory depth,
  // which the sequencer applies in its range checks.
  logic [hec_pkg::CNT_W-1:0] vertex_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= hec_pkg::VC_RESET;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // Output register: the sequencer may take a new input word while a finished word
  // still waits here. It only hands over a result when this register is free or is
  // being emptied in the same cycle.
  logic              out_valid_r;
  hec_pkg::hec_res_t out_res_r;
  logic              out_free;
  logic              seq_res_valid;
  hec_pkg::hec_res_t seq_res;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_coarse_id    = out_res_r.coarse_id;
  assign out_created_new  = out_res_r.created_new;
  assign out_coarse_count = out_res_r.coarse_count;

  // Edge memory holds {best weight, best neighbour} per vertex; the mapping memory holds
  // the mapped flag with the coarse id. Both have a registered read port.
  logic              e_we;
  logic [AW-1:0]     e_waddr, e_raddr;
  logic [EW-1:0]     e_wdata, e_rdata;
  logic              m_we;
  logic [AW-1:0]     m_waddr, m_raddr;
  hec_pkg::hec_map_t m_wdata, m_rdata;
  logic [MW-1:0]     m_rdata_raw;

  assign m_rdata = hec_pkg::hec_map_t'(m_rdata_raw);

  hec_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  hec_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (MW)
  ) u_map_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (MW'(m_wdata)),
    .raddr (m_raddr),
    .rdata (m_rdata_raw)
  );

  // The sequencer works on one word at a time, so no two memory accesses of different
  // words overlap and no forwarding is needed.
  hec_seq #(
    .DEPTH       (DEPTH),
    .AW          (AW),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_vertex    (in_vertex),
    .in_neighbor  (in_neighbor),
    .in_weight    (in_weight),
    .vertex_count (vertex_count_r),
    .out_free     (out_free),
    .res_valid    (seq_res_valid),
    .res          (seq_res),
    .e_we         (e_we),
    .e_waddr      (e_waddr),
    .e_wdata      (e_wdata),
    .e_raddr      (e_raddr),
    .e_rdata      (e_rdata),
    .m_we         (m_we),
    .m_waddr      (m_waddr),
    .m_wdata      (m_wdata),
    .m_raddr      (m_raddr),
    .m_rdata      (m_rdata)
  );

  // The sequencer never overwrites a result word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_res_valid |-> out_free)
    else $error("result handed over while output register was occupied");

  // A result word held off by the receiver stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result word changed or was dropped");

  // A fresh id is only reported on a successful visit, after the count has advanced.
  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.created_new) |->
      (out_res_r.status == hec_pkg::ST_OK && out_res_r.coarse_count != '0))
    else $error("fresh id reported without a successful allocation");

endmodule
